@@ sv/goldbach_partition_finder_core_assert.svh @@
// Assertion macros shared by the Goldbach partition finder modules.
// Depends on nothing; included by the controller and the datapath.
`ifndef GOLDBACH_PARTITION_FINDER_CORE_ASSERT_SVH
`define GOLDBACH_PARTITION_FINDER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GPF_ASSERT_IMPLY(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
		else $error("gpf assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define GPF_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
		else $error("gpf assertion failed");

`endif

@@ sv/gpf_pkg.sv @@
// Shared types and constants of the Goldbach partition finder.
// Depends on nothing; used by the controller, the datapath and the top level.
`default_nettype none

package gpf_pkg;

	localparam int MAX_VALUE_DEF = 16384;
	localparam int FIELD_W = 15;
	localparam int SMALLEST_PRIME = 2;
	localparam int MIN_PAIR_SUM = 4;

	localparam int OP_W = 3;
	localparam logic [OP_W-1:0] OP_NONE    = 3'd0;
	localparam logic [OP_W-1:0] OP_FILL    = 3'd1;
	localparam logic [OP_W-1:0] OP_SV_READ = 3'd2;
	localparam logic [OP_W-1:0] OP_NEXT_I  = 3'd3;
	localparam logic [OP_W-1:0] OP_LOAD_J  = 3'd4;
	localparam logic [OP_W-1:0] OP_MARK    = 3'd5;
	localparam logic [OP_W-1:0] OP_LOAD_N  = 3'd6;
	localparam logic [OP_W-1:0] OP_SEARCH  = 3'd7;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            load_out;
	} gpf_cmd_t;

	typedef struct packed {
		logic fill_last;
		logic sq_over;
		logic prime_bit;
		logic j_over;
		logic n_bad;
		logic s1_valid;
		logic s1_hit;
		logic s1_last;
	} gpf_sts_t;

endpackage

`default_nettype wire

@@ sv/gpf_ctrl.sv @@
// Controller of the Goldbach partition finder: sieve, search and output sequencing.
// Depends on gpf_pkg and the assertion macro header.
`default_nettype none
`include "goldbach_partition_finder_core_assert.svh"

module gpf_ctrl
	import gpf_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  wire logic     out_stall,
	input  wire gpf_sts_t sts,
	output gpf_cmd_t      cmd
);

	localparam logic [2:0] ST_FILL     = 3'd0;
	localparam logic [2:0] ST_SV_READ  = 3'd1;
	localparam logic [2:0] ST_SV_CHECK = 3'd2;
	localparam logic [2:0] ST_SV_MARK  = 3'd3;
	localparam logic [2:0] ST_IDLE     = 3'd4;
	localparam logic [2:0] ST_SEARCH   = 3'd5;
	localparam logic [2:0] ST_OUT      = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;

	always_comb begin
		state_d      = state_q;
		cmd.op       = OP_NONE;
		cmd.load_out = 1'b0;
		case (state_q)
			ST_FILL: begin
				cmd.op = OP_FILL;
				if (sts.fill_last) begin
					state_d = ST_SV_READ;
				end
			end
			ST_SV_READ: begin
				cmd.op  = OP_SV_READ;
				state_d = ST_SV_CHECK;
			end
			ST_SV_CHECK: begin
				if (sts.sq_over) begin
					state_d = ST_IDLE;
				end else if (!sts.prime_bit) begin
					cmd.op  = OP_NEXT_I;
					state_d = ST_SV_READ;
				end else begin
					cmd.op  = OP_LOAD_J;
					state_d = ST_SV_MARK;
				end
			end
			ST_SV_MARK: begin
				if (sts.j_over) begin
					cmd.op  = OP_NEXT_I;
					state_d = ST_SV_READ;
				end else begin
					cmd.op = OP_MARK;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.op  = OP_LOAD_N;
					state_d = sts.n_bad ? ST_OUT : ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				cmd.op = OP_SEARCH;
				if (sts.s1_valid && (sts.s1_hit || sts.s1_last)) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_FILL;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`GPF_ASSERT_NEXT(a_accept_next, clk, arst_n, in_valid && !in_stall,
		state_q == ST_SEARCH || state_q == ST_OUT)
	`GPF_ASSERT_NEXT(a_search_exit, clk, arst_n, state_q == ST_SEARCH,
		state_q == ST_SEARCH || state_q == ST_OUT)
	`GPF_ASSERT_IMPLY(a_load_free, clk, arst_n, cmd.load_out, !out_valid_q || !out_stall)

endmodule

`default_nettype wire

@@ sv/gpf_dp.sv @@
// Datapath of the Goldbach partition finder: prime bitmap memory, sieve counters,
// search pointer and result registers. Depends on gpf_pkg and the assertion macros.
`default_nettype none
`include "goldbach_partition_finder_core_assert.svh"

module gpf_dp
	import gpf_pkg::*;
#(
	parameter int MAX_VALUE = MAX_VALUE_DEF,
	localparam int AW = $clog2(MAX_VALUE + 1)
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire gpf_cmd_t           cmd,
	output gpf_sts_t                sts,
	input  wire logic [FIELD_W-1:0] even_value,
	output logic [FIELD_W-1:0]      small_prime,
	output logic [FIELD_W-1:0]      large_prime,
	output logic                    found
);

	logic              mem_q [0:MAX_VALUE];
	logic [AW-1:0]     f_q;
	logic [AW-1:0]     i_q;
	logic [2*AW-1:0]   sq_q;
	logic [AW:0]       j_q;
	logic [AW-1:0]     n_q;
	logic [AW-1:0]     p_q;
	logic [AW-1:0]     p_s1;
	logic              v_s1;
	logic              rd_a_q;
	logic              rd_b_q;
	logic [FIELD_W-1:0] res_small_q;
	logic [FIELD_W-1:0] res_large_q;
	logic              res_found_q;
	logic [FIELD_W-1:0] small_q;
	logic [FIELD_W-1:0] large_q;
	logic              found_q;

	logic              we;
	logic [AW-1:0]     waddr;
	logic              wdata;
	logic [AW-1:0]     raddr_a;
	logic [AW-1:0]     raddr_b;
	logic              hit;

	assign hit = rd_a_q && rd_b_q;

	always_comb begin
		we    = 1'b0;
		waddr = f_q;
		wdata = 1'b0;
		case (cmd.op)
			OP_FILL: begin
				we    = 1'b1;
				waddr = f_q;
				wdata = (f_q >= AW'(SMALLEST_PRIME));
			end
			OP_MARK: begin
				we    = 1'b1;
				waddr = j_q[AW-1:0];
				wdata = 1'b0;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	assign raddr_a = (cmd.op == OP_SV_READ) ? i_q : p_q;
	assign raddr_b = n_q - p_q;

	always_comb begin
		sts.fill_last = (f_q == AW'(MAX_VALUE));
		sts.sq_over   = (sq_q > (2*AW)'(MAX_VALUE));
		sts.prime_bit = rd_a_q;
		sts.j_over    = (j_q > (AW+1)'(MAX_VALUE));
		sts.n_bad     = (even_value < FIELD_W'(MIN_PAIR_SUM)) ||
			(32'(even_value) > 32'(MAX_VALUE));
		sts.s1_valid  = v_s1;
		sts.s1_hit    = hit;
		sts.s1_last   = (p_s1 == AW'(SMALLEST_PRIME));
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rd_a_q <= mem_q[raddr_a];
		rd_b_q <= mem_q[raddr_b];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			f_q  <= '0;
			i_q  <= AW'(SMALLEST_PRIME);
			v_s1 <= 1'b0;
		end else begin
			if (cmd.op == OP_FILL) begin
				f_q <= f_q + AW'(1);
			end
			if (cmd.op == OP_NEXT_I) begin
				i_q <= i_q + AW'(1);
			end
			if (cmd.op == OP_LOAD_N) begin
				v_s1 <= 1'b0;
			end else if (cmd.op == OP_SEARCH) begin
				v_s1 <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		sq_q <= (2*AW)'(i_q) * (2*AW)'(i_q);
		if (cmd.op == OP_LOAD_J) begin
			j_q <= sq_q[AW:0];
		end else if (cmd.op == OP_MARK) begin
			j_q <= j_q + {1'b0, i_q};
		end
		if (cmd.op == OP_LOAD_N) begin
			n_q         <= AW'(even_value);
			p_q         <= AW'(even_value >> 1);
			res_small_q <= '0;
			res_large_q <= '0;
			res_found_q <= 1'b0;
		end else if (cmd.op == OP_SEARCH) begin
			p_q  <= p_q - AW'(1);
			p_s1 <= p_q;
			if (v_s1 && hit) begin
				res_small_q <= FIELD_W'(p_s1);
				res_large_q <= FIELD_W'(n_q - p_s1);
				res_found_q <= 1'b1;
			end
		end
		if (cmd.load_out) begin
			small_q <= res_small_q;
			large_q <= res_large_q;
			found_q <= res_found_q;
		end
	end

	assign small_prime = small_q;
	assign large_prime = large_q;
	assign found       = found_q;

	`GPF_ASSERT_NEXT(a_pair_sum, clk, arst_n, cmd.op == OP_SEARCH && v_s1 && hit,
		res_found_q && (32'(res_small_q) + 32'(res_large_q) == 32'(n_q)))
	`GPF_ASSERT_IMPLY(a_search_floor, clk, arst_n, cmd.op == OP_SEARCH, p_q != '0)

endmodule

`default_nettype wire

@@ sv/goldbach_partition_finder_core.sv @@
// Goldbach partition finder, top level: joins the controller and the datapath.
// Depends on gpf_pkg, gpf_ctrl and gpf_dp.
//
// Usage: one request on the input channel carries even_value; one request on the
// output channel returns small_prime, large_prime and found. An input is taken
// when in_valid is high and in_stall is low; a result is taken when out_valid is
// high and out_stall is low.
// After reset the block fills its prime bitmap and then runs the sieve over
// every prime up to the square root of MAX_VALUE; in_stall stays high during
// that time. An accepted request steps its candidate down from n/2, one
// bitmap read pair per cycle, until a pair is found or the candidate 2 has
// been checked; the result then moves to the output register and out_valid
// rises. Out-of-range values and values below four skip the search.
// One request is worked on at a time; the next is accepted on the cycle after
// the result is moved into the output register.
// While the receiver stalls, the result is held in the output register and a
// finished search waits in the controller until that register frees up.
`default_nettype none

module goldbach_partition_finder_core
	import gpf_pkg::*;
#(
	parameter int MAX_VALUE = MAX_VALUE_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [FIELD_W-1:0] even_value,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [FIELD_W-1:0]      small_prime,
	output logic [FIELD_W-1:0]      large_prime,
	output logic                    found
);

	gpf_cmd_t cmd;
	gpf_sts_t sts;

	gpf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	gpf_dp #(
		.MAX_VALUE (MAX_VALUE)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.even_value  (even_value),
		.small_prime (small_prime),
		.large_prime (large_prime),
		.found       (found)
	);

endmodule

`default_nettype wire
